// ===== hw/rtl/madt_pkg.sv =====
// Shared types and constants of the MADT entry parser.
package madt_pkg;

  localparam int unsigned QDEPTH = 4;

  // MADT entry types handled by the walk.
  localparam logic [7:0] ENTRY_LAPIC     = 8'd0;
  localparam logic [7:0] ENTRY_IOAPIC    = 8'd1;
  localparam logic [7:0] ENTRY_LAPIC_OVR = 8'd5;

  localparam logic RECORD_PROCESSOR = 1'b0;
  localparam logic RECORD_SUMMARY   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [7:0]  apic_id;
    logic [7:0]  proc_id;
    logic [63:0] lapic;
    logic [31:0] ioapic;
    logic [31:0] gsi;
    logic [4:0]  count;
    logic        stop;
    logic        last;
  } madt_rec_t;

  // Records produced by one table byte, already compacted into first/second.
  typedef struct packed {
    logic [1:0] n;
    madt_rec_t  first;
    madt_rec_t  second;
  } madt_push_t;

endpackage

// ===== hw/rtl/madt_parse_core.sv =====
// Table walk state and the per-byte parse logic.
module madt_parse_core #(
  parameter int unsigned MAX_PROCESSORS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                table_start,
  output madt_pkg::madt_push_t push
);
  import madt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PROCESSORS + 1);

  logic [31:0]   boff, tlen, c_boff, c_tlen, tlen_next;
  logic [7:0]    eoff, etype, elen, c_eoff, c_etype, c_elen;
  logic [7:0]    eoff_next, etype_next, elen_next, eo_m4;
  logic [63:0]   fshift, lapic, c_fshift, c_lapic, fshift_next, lapic_next;
  logic [31:0]   ioapic, gsi, c_ioapic, c_gsi, ioapic_next, gsi_next;
  logic [CW-1:0] cnt, c_cnt, cnt_next;
  logic [15:0]   pend, c_pend, pend_next;
  logic          stopped, c_stopped, stopped_next;
  logic          done, done_next;
  logic          active, emit_proc, emit_sum;
  logic [CW+3:0] slot_ext;
  logic [CW+4:0] count_ext;
  madt_rec_t     proc_rec, sum_rec;

  assign active = take && (table_start || !done);

  // A table start clears the parse before this byte is taken.
  assign c_boff    = table_start ? '0 : boff;
  assign c_tlen    = table_start ? '0 : tlen;
  assign c_eoff    = table_start ? '0 : eoff;
  assign c_etype   = table_start ? '0 : etype;
  assign c_elen    = table_start ? '0 : elen;
  assign c_fshift  = table_start ? '0 : fshift;
  assign c_lapic   = table_start ? '0 : lapic;
  assign c_ioapic  = table_start ? '0 : ioapic;
  assign c_gsi     = table_start ? '0 : gsi;
  assign c_cnt     = table_start ? '0 : cnt;
  assign c_pend    = table_start ? '0 : pend;
  assign c_stopped = table_start ? 1'b0 : stopped;
  assign eo_m4     = c_eoff - 8'd4;

  always_comb begin
    tlen_next    = c_tlen;
    eoff_next    = c_eoff;
    etype_next   = c_etype;
    elen_next    = c_elen;
    fshift_next  = c_fshift;
    lapic_next   = c_lapic;
    ioapic_next  = c_ioapic;
    gsi_next     = c_gsi;
    cnt_next     = c_cnt;
    pend_next    = c_pend;
    stopped_next = c_stopped;
    emit_proc    = 1'b0;

    if (c_boff >= 32'd4 && c_boff <= 32'd7) begin
      tlen_next = c_tlen | (32'(data_byte) << {c_boff[1:0], 3'b000});
    end else if (c_boff >= 32'd36 && c_boff <= 32'd39) begin
      fshift_next = c_fshift | (64'(data_byte) << {c_boff[1:0], 3'b000});
      if (c_boff == 32'd39) begin
        lapic_next  = {32'd0, fshift_next[31:0]};
        fshift_next = '0;
      end
    end else if (c_boff >= 32'd44 && !c_stopped) begin
      if (c_eoff == 8'd0) begin
        etype_next  = data_byte;
        fshift_next = '0;
        pend_next   = '0;
      end else if (c_eoff == 8'd1) begin
        elen_next = data_byte;
        if (data_byte < 8'd2) begin
          stopped_next = 1'b1;
        end
      end else begin
        if (c_eoff == 8'd2) begin
          pend_next[7:0] = c_pend[7:0] | data_byte;
        end
        if (c_eoff == 8'd3) begin
          pend_next[15:8] = c_pend[15:8] | data_byte;
        end
        if (c_eoff >= 8'd4 && c_eoff <= 8'd11) begin
          fshift_next = c_fshift | (64'(data_byte) << {eo_m4[2:0], 3'b000});
        end
        if (c_eoff == 8'd7 && c_etype == ENTRY_LAPIC && c_elen >= 8'd8 &&
            fshift_next[0] && c_cnt < CW'(MAX_PROCESSORS)) begin
          emit_proc = 1'b1;
          cnt_next  = c_cnt + CW'(1);
        end
        if (c_eoff == 8'd11 && c_elen >= 8'd12) begin
          if (c_etype == ENTRY_IOAPIC && c_ioapic == 32'd0) begin
            ioapic_next = fshift_next[31:0];
            gsi_next    = fshift_next[63:32];
          end else if (c_etype == ENTRY_LAPIC_OVR) begin
            lapic_next = fshift_next;
          end
        end
      end
      if (!stopped_next) begin
        if (c_eoff >= 8'd1 && {1'b0, c_eoff} + 9'd1 >= {1'b0, elen_next}) begin
          eoff_next = '0;
        end else begin
          eoff_next = c_eoff + 8'd1;
        end
      end
    end
  end

  assign emit_sum  = c_boff >= 32'd7 && ({1'b0, c_boff} + 33'd1 >= {1'b0, tlen_next});
  assign done_next = emit_sum ? 1'b1 : 1'b0;
  assign slot_ext  = {4'd0, c_cnt};
  assign count_ext = {5'd0, cnt_next};

  always_comb begin
    proc_rec         = '0;
    proc_rec.kind    = RECORD_PROCESSOR;
    proc_rec.slot    = slot_ext[3:0];
    proc_rec.apic_id = pend_next[15:8];
    proc_rec.proc_id = pend_next[7:0];
    proc_rec.lapic   = lapic_next;
    proc_rec.ioapic  = ioapic_next;
    proc_rec.gsi     = gsi_next;
    proc_rec.count   = count_ext[4:0];

    sum_rec        = '0;
    sum_rec.kind   = RECORD_SUMMARY;
    sum_rec.lapic  = lapic_next;
    sum_rec.ioapic = ioapic_next;
    sum_rec.gsi    = gsi_next;
    sum_rec.count  = count_ext[4:0];
    sum_rec.stop   = stopped_next;
    sum_rec.last   = 1'b1;

    push.first  = emit_proc ? proc_rec : sum_rec;
    push.second = sum_rec;
    push.n      = active ? ({1'b0, emit_proc} + {1'b0, emit_sum}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boff    <= '0;
      tlen    <= '0;
      eoff    <= '0;
      etype   <= '0;
      elen    <= '0;
      fshift  <= '0;
      lapic   <= '0;
      ioapic  <= '0;
      gsi     <= '0;
      cnt     <= '0;
      pend    <= '0;
      stopped <= 1'b0;
      done    <= 1'b1;
    end else if (active) begin
      boff    <= c_boff + 32'd1;
      tlen    <= tlen_next;
      eoff    <= eoff_next;
      etype   <= etype_next;
      elen    <= elen_next;
      fshift  <= fshift_next;
      lapic   <= lapic_next;
      ioapic  <= ioapic_next;
      gsi     <= gsi_next;
      cnt     <= cnt_next;
      pend    <= pend_next;
      stopped <= stopped_next;
      done    <= done_next;
    end
  end

endmodule

// ===== hw/rtl/madt_out_queue.sv =====
// Small result queue that takes up to two records per cycle and gives one.
module madt_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  madt_pkg::madt_push_t push,
  output logic                 room,
  output logic                 head_valid,
  output madt_pkg::madt_rec_t  head,
  input  logic                 pop
);
  import madt_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  madt_rec_t       mem [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr, wr_ptr1;
  logic [PW:0]     count;
  logic            pop_ok;

  assign wr_ptr1    = wr_ptr + PW'(1);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign pop_ok     = pop && head_valid;
  // Room for two records, the most one table byte can produce.
  assign room       = count <= (PW + 1)'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop_ok);
      count  <= count + (PW + 1)'(push.n) - (PW + 1)'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.second;
    end
  end

endmodule

// ===== hw/rtl/madt_entry_parser_unit.sv =====
// MADT entry parser: walks an ACPI MADT byte stream and reports processors and a summary.
//
// Input channel (s_*): one table byte per transaction in s_tdata; s_tuser marks the
// first byte of a new table and restarts the parse. Bytes that arrive while no table
// is open are taken and dropped.
// Output channel (m_*): one record per transaction. m_tuser is the record kind
// (processor record or end-of-table summary), m_tlast is set on the summary.
// One byte is taken every cycle. A byte can yield up to two records (a processor
// record followed by the summary); the four-entry result queue absorbs those, so the
// input stalls only while fewer than two queue entries are free.
// A record leaves on m_* once the byte that caused it has passed the input register
// and the parse logic has written the record into the result queue.
// Reset clears the walk and empties the queue; the block then waits for a table start.
// When the receiver stalls the queue fills and s_tready drops; no record is lost.
module madt_entry_parser_unit #(
  parameter int unsigned MAX_PROCESSORS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_tuser,   // [0] table_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] slot_index, [11:4] apic_id, [19:12] processor_id, [83:20] lapic_address,
  // [115:84] ioapic_address, [147:116] gsi_base, [152:148] processor_count,
  // [153] stop_status, [159:154] zero
  output logic [159:0] m_tdata,
  output logic [0:0]   m_tuser,   // [0] record_kind
  output logic         m_tlast
);
  import madt_pkg::*;

  logic       in_valid, take, room;
  logic [7:0] in_byte;
  logic       in_start;
  madt_push_t push;
  madt_rec_t  head;

  assign take     = in_valid && room;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  madt_parse_core #(
    .MAX_PROCESSORS(MAX_PROCESSORS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (in_byte),
    .table_start (in_start),
    .push        (push)
  );

  madt_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (m_tvalid),
    .head       (head),
    .pop        (m_tready)
  );

  assign m_tdata = {6'd0, head.stop, head.count, head.gsi, head.ioapic, head.lapic,
                    head.proc_id, head.apic_id, head.slot};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule
